### sv/sbspc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo bus status packet checker package
// Sizes, framing constants and result status codes shared by the block.
// ---------------------------------------------------------------------------
package sbspc_pkg;

  // Parameter buffer depth and derived widths
  localparam int MAX_PARAMS = 32;
  localparam int PARAM_AW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 3;

  // Framing
  localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;
  localparam logic [BYTE_W-1:0] ID_RESET     = 8'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ID       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LENLOW   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LONG     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd6;

endpackage

### sv/sbspc_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received byte and its window flags.
// ---------------------------------------------------------------------------
interface sbspc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_req;
  logic       window_end;

  modport source (output valid, output rx_byte, output start_req,
                  output window_end, input ready);
  modport sink   (input valid, input rx_byte, input start_req,
                  input window_end, output ready);
endinterface

### sv/sbspc_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one parsed parameter or status item.
// ---------------------------------------------------------------------------
interface sbspc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] param_byte;
  logic [4:0] param_index;
  logic [5:0] param_count;
  logic [7:0] servo_error;
  logic [2:0] status;
  logic       has_param;
  logic       last;

  modport source (output valid, output param_byte, output param_index,
                  output param_count, output servo_error, output status,
                  output has_param, output last, input ready);
  modport sink   (input valid, input param_byte, input param_index,
                  input param_count, input servo_error, input status,
                  input has_param, input last, output ready);
endinterface

### sv/sbspc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sbspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/servo_bus_status_packet_checker_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo bus status packet checker
// Parses status packets byte by byte, buffers parameters in a RAM and
// emits them once the checksum has been verified.
// ---------------------------------------------------------------------------
//  channel   dir  handshake        content
//  rx_i      in   valid/ready      rx_byte, start_req, window_end
//  res_o     out  valid/ready      param/status item
//  cfg       in   cfg_we_i         expected_id
//
//  One input item per cycle while parsing; no result item lost on stall.
//  A good checksum with N parameters holds rx_i.ready low while the N items
//  stream out of the parameter RAM, one per cycle while res_o takes them, through
//  the single RAM read port with its registered read data.
//  Reset clears the parser state; the parameter RAM needs no clearing.
//  res_o is a registered output; stalls there stall the input side.
// ---------------------------------------------------------------------------
module servo_bus_status_packet_checker_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [sbspc_pkg::BYTE_W-1:0] cfg_wdata_i,
  sbspc_in_if.sink              rx_i,
  sbspc_out_if.source           res_o
);
  import sbspc_pkg::*;

  // Parser phases
  localparam logic [2:0] PH_HDR1  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_CHK   = 3'd6;

  logic [BYTE_W-1:0] exp_id_q;
  logic [2:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]  nparam_q, nparam_d;
  logic [BYTE_W-1:0] err_q, err_d;
  logic              fin_q, fin_d;

  // Emission control
  logic              emit_q, emit_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  pidx_q, pidx_d;

  // Output register
  logic                out_v_q, out_v_d;
  logic [BYTE_W-1:0]   o_byte_q, o_byte_d;
  logic [INDEX_W-1:0]  o_idx_q, o_idx_d;
  logic [COUNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [BYTE_W-1:0]   o_err_q, o_err_d;
  logic [STATUS_W-1:0] o_st_q, o_st_d;
  logic                o_hasp_q, o_hasp_d;
  logic                o_last_q, o_last_d;

  // RAM ports
  logic                ram_we, ram_re;
  logic [PARAM_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic              can_load, acc, load, issue, pend_last;
  logic [2:0]        ph_e;
  logic [CNT_W-1:0]  seen_e, nparam_e, seen_inc;
  logic [BYTE_W-1:0] sum_e, b, len_m2;
  logic              fin_e;
  logic              res_v;
  logic [STATUS_W-1:0] res_st;
  logic              res_ok;

  assign can_load = !out_v_q || res_o.ready;
  assign rx_i.ready = !emit_q && can_load;
  assign acc = rx_i.valid && rx_i.ready;
  assign load = pend_q && can_load;
  assign issue = emit_q && (iss_q < nparam_q) && (!pend_q || load);
  assign pend_last = (pidx_q + CNT_W'(1)) == nparam_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= ID_RESET;
    end else if (cfg_we_i) begin
      exp_id_q <= cfg_wdata_i;
    end
  end

  // Parser step on an accepted item
  always_comb begin
    b        = rx_i.rx_byte;
    ph_e     = rx_i.start_req ? PH_HDR1 : phase_q;
    seen_e   = rx_i.start_req ? '0 : seen_q;
    sum_e    = rx_i.start_req ? '0 : sum_q;
    nparam_e = rx_i.start_req ? '0 : nparam_q;
    fin_e    = rx_i.start_req ? 1'b0 : fin_q;
    err_d    = rx_i.start_req ? '0 : err_q;
    len_m2   = b - LEN_OVERHEAD;
    seen_inc = seen_e + CNT_W'(1);

    phase_d  = ph_e;
    seen_d   = seen_e;
    sum_d    = sum_e;
    nparam_d = nparam_e;
    fin_d    = fin_e;
    res_v    = 1'b0;
    res_st   = ST_OK;
    res_ok   = 1'b0;
    ram_we   = 1'b0;
    ram_waddr = seen_e[PARAM_AW-1:0];
    emit_d   = emit_q;
    iss_d    = iss_q;

    if (!acc) begin
      phase_d  = phase_q;
      seen_d   = seen_q;
      sum_d    = sum_q;
      nparam_d = nparam_q;
      fin_d    = fin_q;
      err_d    = err_q;
    end else if (!fin_e) begin
      if (rx_i.window_end) begin
        fin_d  = 1'b1;
        res_v  = 1'b1;
        res_st = ST_SHORT;
      end else begin
        unique case (ph_e)
          PH_HDR1: begin
            if (b != HDR_BYTE) begin
              fin_d = 1'b1; res_v = 1'b1; res_st = ST_HEADER;
            end else begin
              phase_d = PH_HDR2;
            end
          end
          PH_HDR2: begin
            if (b != HDR_BYTE) begin
              fin_d = 1'b1; res_v = 1'b1; res_st = ST_HEADER;
            end else begin
              phase_d = PH_ID;
            end
          end
          PH_ID: begin
            if (b != exp_id_q) begin
              fin_d = 1'b1; res_v = 1'b1; res_st = ST_ID;
            end else begin
              sum_d   = sum_e + b;
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b < LEN_OVERHEAD) begin
              fin_d = 1'b1; res_v = 1'b1; res_st = ST_LENLOW;
            end else if (32'(len_m2) > MAX_PARAMS) begin
              fin_d = 1'b1; res_v = 1'b1; res_st = ST_LONG;
            end else begin
              nparam_d = CNT_W'(len_m2);
              sum_d    = sum_e + b;
              phase_d  = PH_ERR;
            end
          end
          PH_ERR: begin
            err_d   = b;
            sum_d   = sum_e + b;
            seen_d  = '0;
            phase_d = (nparam_e == '0) ? PH_CHK : PH_PARAM;
          end
          PH_PARAM: begin
            ram_we  = 1'b1;
            sum_d   = sum_e + b;
            seen_d  = seen_inc;
            if (seen_inc >= nparam_e) begin
              phase_d = PH_CHK;
            end
          end
          PH_CHK: begin
            fin_d = 1'b1;
            if (~sum_e != b) begin
              res_v = 1'b1; res_st = ST_CHECKSUM;
            end else if (nparam_e == '0) begin
              res_v = 1'b1; res_ok = 1'b1;
            end else begin
              emit_d = 1'b1;
              iss_d  = '0;
            end
          end
          default: begin
            fin_d = 1'b1; res_v = 1'b1; res_st = ST_HEADER;
          end
        endcase
      end
    end

    // Parameter burst from the RAM
    if (issue) begin
      iss_d = iss_q + CNT_W'(1);
    end
    if (load && pend_last) begin
      emit_d = 1'b0;
    end
  end

  assign ram_re    = issue;
  assign ram_raddr = iss_q[PARAM_AW-1:0];
  assign pend_d    = issue ? 1'b1 : (load ? 1'b0 : pend_q);
  assign pidx_d    = issue ? iss_q : pidx_q;

  // Output register load
  always_comb begin
    out_v_d   = out_v_q;
    o_byte_d  = o_byte_q;
    o_idx_d   = o_idx_q;
    o_cnt_d   = o_cnt_q;
    o_err_d   = o_err_q;
    o_st_d    = o_st_q;
    o_hasp_d  = o_hasp_q;
    o_last_d  = o_last_q;
    if (can_load) begin
      out_v_d = res_v || load;
      if (load) begin
        o_byte_d = ram_rdata;
        o_idx_d  = pidx_q[INDEX_W-1:0];
        o_cnt_d  = COUNT_W'(nparam_q);
        o_err_d  = err_q;
        o_st_d   = ST_OK;
        o_hasp_d = 1'b1;
        o_last_d = pend_last;
      end else begin
        o_byte_d = '0;
        o_idx_d  = '0;
        o_cnt_d  = '0;
        o_err_d  = res_ok ? err_d : '0;
        o_st_d   = res_st;
        o_hasp_d = 1'b0;
        o_last_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR1;
      seen_q   <= '0;
      sum_q    <= '0;
      nparam_q <= '0;
      err_q    <= '0;
      fin_q    <= 1'b0;
      emit_q   <= 1'b0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
      pidx_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      sum_q    <= sum_d;
      nparam_q <= nparam_d;
      err_q    <= err_d;
      fin_q    <= fin_d;
      emit_q   <= emit_d;
      iss_q    <= iss_d;
      pend_q   <= pend_d;
      pidx_q   <= pidx_d;
      out_v_q  <= out_v_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    o_byte_q <= o_byte_d;
    o_idx_q  <= o_idx_d;
    o_cnt_q  <= o_cnt_d;
    o_err_q  <= o_err_d;
    o_st_q   <= o_st_d;
    o_hasp_q <= o_hasp_d;
    o_last_q <= o_last_d;
  end

  // Parameter store
  sbspc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PARAMS),
    .AW    (PARAM_AW)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (b),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid       = out_v_q;
  assign res_o.param_byte  = o_byte_q;
  assign res_o.param_index = o_idx_q;
  assign res_o.param_count = o_cnt_q;
  assign res_o.servo_error = o_err_q;
  assign res_o.status      = o_st_q;
  assign res_o.has_param   = o_hasp_q;
  assign res_o.last        = o_last_q;

  // Checks
  a_no_rx_during_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> !rx_i.ready)
    else $error("input taken during parameter burst");

  a_status_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.has_param) |-> res_o.last)
    else $error("status item not marked last");

  a_param_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.has_param) |-> (res_o.status == ST_OK))
    else $error("parameter item with error status");

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.has_param && res_o.last) |->
      (res_o.param_index == INDEX_W'(res_o.param_count - COUNT_W'(1))))
    else $error("last parameter index does not match count");

endmodule

### dv/sbspc_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Status packet result checker
// Watches the receive and result channels, runs a parser of its own on every
// accepted byte and compares each result item with the oldest prediction.
// ---------------------------------------------------------------------------
module sbspc_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sbspc_pkg::BYTE_W-1:0] cfg_wdata_i,
  sbspc_in_if                          rx_i,
  sbspc_out_if                         res_i,
  output int unsigned                  pending_o,
  output int unsigned                  fail_count_o
);
  import sbspc_pkg::*;

  typedef enum logic [2:0] {
    WAIT_HDR1,
    WAIT_HDR2,
    WAIT_ID,
    WAIT_LEN,
    WAIT_ERR,
    WAIT_PARAM,
    WAIT_CHK
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   param_byte;
    logic [INDEX_W-1:0]  param_index;
    logic [COUNT_W-1:0]  param_count;
    logic [BYTE_W-1:0]   servo_error;
    logic [STATUS_W-1:0] status;
    logic                has_param;
    logic                last;
  } status_item_t;

  // Parser copy
  parse_phase_e      parse_phase;
  logic [BYTE_W-1:0] exp_id;
  logic [BYTE_W-1:0] parse_seen;
  logic [BYTE_W-1:0] parse_sum;
  logic [BYTE_W-1:0] parse_len;
  logic [BYTE_W-1:0] parse_err;
  logic [BYTE_W-1:0] param_buf [MAX_PARAMS];
  logic              parse_done;

  status_item_t expected_results [$];
  status_item_t got_item;
  status_item_t want_item;
  int unsigned  mismatches = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] result check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic void restart_parse();
    parse_phase = WAIT_HDR1;
    parse_seen  = '0;
    parse_sum   = '0;
    parse_len   = '0;
    parse_err   = '0;
    parse_done  = 1'b0;
  endfunction

  // A failure ends the packet with a single status-only item
  function automatic void push_fault(input logic [STATUS_W-1:0] st);
    status_item_t item;
    item        = '0;
    item.status = st;
    item.last   = 1'b1;
    parse_done  = 1'b1;
    expected_results.push_back(item);
  endfunction

  // Advance the parser by one accepted item and queue what it yields
  function automatic void parse_rx_item(input logic [BYTE_W-1:0] b, input logic start,
                                        input logic wend);
    int           nparam;
    logic [7:0]   inv_sum;
    status_item_t item;
    if (start) restart_parse();
    if (parse_done) return;
    if (wend) begin
      push_fault(ST_SHORT);
      return;
    end
    nparam = (parse_len >= LEN_OVERHEAD) ? int'(parse_len) - int'(LEN_OVERHEAD) : 0;
    case (parse_phase)
      WAIT_HDR1: begin
        if (b != HDR_BYTE) push_fault(ST_HEADER);
        else parse_phase = WAIT_HDR2;
      end
      WAIT_HDR2: begin
        if (b != HDR_BYTE) push_fault(ST_HEADER);
        else parse_phase = WAIT_ID;
      end
      WAIT_ID: begin
        if (b != exp_id) begin
          push_fault(ST_ID);
        end else begin
          parse_sum   = parse_sum + b;
          parse_phase = WAIT_LEN;
        end
      end
      WAIT_LEN: begin
        if (b < LEN_OVERHEAD) begin
          push_fault(ST_LENLOW);
        end else if (int'(b) - int'(LEN_OVERHEAD) > MAX_PARAMS) begin
          push_fault(ST_LONG);
        end else begin
          parse_len   = b;
          parse_sum   = parse_sum + b;
          parse_phase = WAIT_ERR;
        end
      end
      WAIT_ERR: begin
        parse_err   = b;
        parse_sum   = parse_sum + b;
        parse_seen  = '0;
        parse_phase = (nparam == 0) ? WAIT_CHK : WAIT_PARAM;
      end
      WAIT_PARAM: begin
        if (int'(parse_seen) < MAX_PARAMS) param_buf[parse_seen[PARAM_AW-1:0]] = b;
        parse_sum  = parse_sum + b;
        parse_seen = parse_seen + 8'd1;
        if (int'(parse_seen) >= nparam) parse_phase = WAIT_CHK;
      end
      WAIT_CHK: begin
        inv_sum = ~parse_sum;
        if (inv_sum != b) begin
          push_fault(ST_CHECKSUM);
        end else begin
          parse_done = 1'b1;
          if (nparam == 0) begin
            item             = '0;
            item.servo_error = parse_err;
            item.status      = ST_OK;
            item.last        = 1'b1;
            expected_results.push_back(item);
          end else begin
            for (int i = 0; i < nparam && i < MAX_PARAMS; i++) begin
              item.param_byte  = param_buf[i];
              item.param_index = i[INDEX_W-1:0];
              item.param_count = nparam[COUNT_W-1:0];
              item.servo_error = parse_err;
              item.status      = ST_OK;
              item.has_param   = 1'b1;
              item.last        = (i + 1 == nparam);
              expected_results.push_back(item);
            end
          end
        end
      end
      default: push_fault(ST_HEADER);
    endcase
  endfunction

  // Compare results, then predict from this edge's input item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      exp_id = ID_RESET;
      restart_parse();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got_item = {res_i.param_byte, res_i.param_index, res_i.param_count,
                    res_i.servo_error, res_i.status, res_i.has_param, res_i.last};
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected item, status %0d", got_item.status));
        end else begin
          want_item = expected_results.pop_front();
          compare_field("param_byte", got_item.param_byte, want_item.param_byte);
          compare_field("param_index", 8'(got_item.param_index), 8'(want_item.param_index));
          compare_field("param_count", 8'(got_item.param_count), 8'(want_item.param_count));
          compare_field("servo_error", got_item.servo_error, want_item.servo_error);
          compare_field("status", 8'(got_item.status), 8'(want_item.status));
          compare_field("has_param", 8'(got_item.has_param), 8'(want_item.has_param));
          compare_field("last", 8'(got_item.last), 8'(want_item.last));
        end
      end
      if (rx_i.valid && rx_i.ready)
        parse_rx_item(rx_i.rx_byte, rx_i.start_req, rx_i.window_end);
      if (cfg_we_i) exp_id = cfg_wdata_i;
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### dv/servo_bus_status_packet_checker_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo bus status packet checker testbench
// Feeds directed and random status packets, good and broken, under three
// backpressure mixes and several expected ids; the result checker beside
// the block predicts and compares every result item.
// ---------------------------------------------------------------------------
module servo_bus_status_packet_checker_unit_test;
  import sbspc_pkg::*;

  localparam int HOLD_OFF   = 8;
  localparam int IDLE_LIMIT = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BYTE_W-1:0] cfg_wdata_i;
  int unsigned       pending;
  int unsigned       fail_count;

  sbspc_in_if  rx_ch ();
  sbspc_out_if res_ch ();

  servo_bus_status_packet_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_ch),
    .res_o       (res_ch)
  );

  sbspc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_i         (rx_ch),
    .res_i        (res_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  int unsigned       items_sent;
  logic [BYTE_W-1:0] cur_id;
  logic [BYTE_W-1:0] pkt [$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver backpressure
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: cycles without any item moving
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("servo_bus_status_packet_checker_unit_test NOT OK");
    $finish;
  end

  // Offer one item, with a random gap first, and hold it until taken
  task automatic send_item(input logic [7:0] rx_byte, input logic start_req,
                           input logic window_end);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid      <= 1'b1;
    rx_ch.rx_byte    <= rx_byte;
    rx_ch.start_req  <= start_req;
    rx_ch.window_end <= window_end;
    do @(posedge clk_i); while (rx_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Stop sending and let every predicted item come out
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  task automatic write_expected_id(input logic [7:0] id);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_id = id;
  endtask

  // Well-formed packet for the current id with random parameters
  task automatic build_packet(input int nparam, input logic [7:0] err);
    logic [7:0] sum;
    logic [7:0] len;
    logic [7:0] p;
    len = 8'(nparam + 2);
    sum = cur_id + len + err;
    pkt.delete();
    pkt.push_back(HDR_BYTE);
    pkt.push_back(HDR_BYTE);
    pkt.push_back(cur_id);
    pkt.push_back(len);
    pkt.push_back(err);
    for (int i = 0; i < nparam; i++) begin
      p = 8'($urandom);
      pkt.push_back(p);
      sum = sum + p;
    end
    pkt.push_back(~sum);
  endtask

  // First count bytes of the packet, the first one opening the window
  task automatic send_prefix(input int count);
    for (int i = 0; i < count; i++) send_item(pkt[i], i == 0, 1'b0);
  endtask

  function automatic int pick_nparam();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return MAX_PARAMS;
    if (r < 12) return $urandom_range(5, MAX_PARAMS - 1);
    return $urandom_range(0, 4);
  endfunction

  // One random packet: mostly good, the rest broken or noise
  task automatic send_random_packet();
    int unsigned pick;
    int unsigned pos;
    int unsigned cut;
    logic [7:0]  v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      build_packet(pick_nparam(), 8'($urandom));
      send_prefix(pkt.size());
    end else if (pick < 65) begin
      build_packet(pick_nparam(), 8'($urandom));
      pkt[pkt.size() - 1] = pkt[pkt.size() - 1] ^ 8'($urandom_range(1, 255));
      send_prefix(pkt.size());
    end else if (pick < 77) begin
      // cut short by window end, or abandoned for the next start
      build_packet(pick_nparam(), 8'($urandom));
      cut = $urandom_range(0, pkt.size() - 1);
      send_prefix(cut);
      if (cut == 0 || $urandom_range(1)) send_item(8'($urandom), cut == 0, 1'b1);
    end else if (pick < 89) begin
      // header, id or length fault
      build_packet(pick_nparam(), 8'($urandom));
      pos = $urandom_range(0, 3);
      case (pos)
        0, 1: begin
          do v = 8'($urandom); while (v == HDR_BYTE);
          pkt[pos] = v;
        end
        2: begin
          do v = 8'($urandom); while (v == cur_id);
          pkt[2] = v;
        end
        default: begin
          pkt[3] = $urandom_range(1) ? 8'($urandom_range(0, 1))
                                     : 8'($urandom_range(MAX_PARAMS + 3, 255));
        end
      endcase
      send_prefix(pos + 1);
    end else begin
      cut = $urandom_range(1, 4);
      for (int i = 0; i < cut; i++)
        send_item(8'($urandom), i == 0 || $urandom_range(3) == 0, $urandom_range(7) == 0);
    end
    // stray trailing item
    if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b0, 1'($urandom_range(1)));
  endtask

  task automatic run_random(input int unsigned upto);
    while (items_sent < upto) send_random_packet();
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    rx_ch.valid      <= 1'b0;
    rx_ch.rx_byte    <= '0;
    rx_ch.start_req  <= 1'b0;
    rx_ch.window_end <= 1'b0;
    src_idle_pct = 38;
    snk_idle_pct = 71;
    items_sent   = 0;
    cur_id       = ID_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset id, short, header, id and length faults, a bare good packet
    send_item(8'h5A, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(HDR_BYTE, 1'b1, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(HDR_BYTE, 1'b1, 1'b0);
    send_item(HDR_BYTE, 1'b0, 1'b0);
    send_item(8'h02, 1'b0, 1'b0);
    send_item(HDR_BYTE, 1'b1, 1'b0);
    send_item(HDR_BYTE, 1'b0, 1'b0);
    send_item(cur_id, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(HDR_BYTE, 1'b1, 1'b0);
    send_item(HDR_BYTE, 1'b0, 1'b0);
    send_item(cur_id, 1'b0, 1'b0);
    send_item(8'(MAX_PARAMS + 3), 1'b0, 1'b0);
    build_packet(0, 8'hFF);
    send_prefix(pkt.size());
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(HDR_BYTE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    write_expected_id(8'hFF);
    run_random(items_sent + 18);

    src_idle_pct = 71;
    snk_idle_pct = 38;
    write_expected_id(8'h00);
    build_packet(MAX_PARAMS, 8'h00);
    send_prefix(pkt.size());
    run_random(items_sent + 12);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_expected_id(8'($urandom));
    run_random(items_sent + 15);

    drain_results();
    if (fail_count == 0 && pending == 0)
      $display("servo_bus_status_packet_checker_unit_test OK");
    else
      $display("servo_bus_status_packet_checker_unit_test NOT OK");
    $finish;
  end

endmodule
